// ===== rtl/bgft_pkg.sv =====
// Shared constants, lane type and arctangent table for the body/ground frame transform.
package bgft_pkg;

    // Field widths and rotation depth.
    localparam int COORD_WIDTH     = 32;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;

    // Internal angle is a 32-bit binary angle, 2^31 = pi.
    localparam int ZW        = 32;
    // Rotation vector in Q.30 with headroom for growth and truncation.
    localparam int CS_W      = 34;
    localparam int FRAC      = 30;
    // Point or point-minus-position difference.
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = DIFF_W + CS_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RND_W     = ACC_W - FRAC;
    localparam int TAB_IDX_W = 5;

    // Mode codes.
    localparam logic MODE_B2G = 1'b0;
    localparam logic MODE_G2B = 1'b1;

    // Start magnitude: reciprocal of the infinite-stage rotation gain in Q.30.
    localparam logic signed [CS_W-1:0] GAIN_Q30 = CS_W'(652032874);

    // Data that travels down the rotation chain with each item.
    typedef struct packed {
        logic                           mode;
        logic signed [DIFF_W-1:0]       a;
        logic signed [DIFF_W-1:0]       b;
        logic signed [COORD_WIDTH-1:0]  ox;
        logic signed [COORD_WIDTH-1:0]  oy;
        logic signed [CS_W-1:0]         x;
        logic signed [CS_W-1:0]         y;
        logic        [ZW-1:0]           z;
    } t_lane;

    // Arctangent of 2^-i in 32-bit binary angle units.
    function automatic logic [ZW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bgft_entry.sv =====
// Input stage: forms the operands, the offsets and the rotation start vector.
module bgft_entry
    import bgft_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic                           i_mode,
    input  logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [COORD_WIDTH-1:0]  i_point_y,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_y,
    input  logic signed [ANGLE_WIDTH-1:0]  i_heading,
    output logic                           o_valid,
    output t_lane                          o_lane
);

    logic   r_valid;
    t_lane  r_lane;
    t_lane  n_lane;
    logic [ZW-1:0] z_wide;

    // Widen the heading so that the full range spans minus pi to pi.
    assign z_wide = {i_heading, {(ZW - ANGLE_WIDTH){1'b0}}};

    // Ground to body works on the difference; body to ground adds the position at the end.
    always_comb begin
        n_lane.mode = i_mode;
        if (i_mode == MODE_G2B) begin
            n_lane.a  = DIFF_W'(i_point_x) - DIFF_W'(i_pos_x);
            n_lane.b  = DIFF_W'(i_point_y) - DIFF_W'(i_pos_y);
            n_lane.ox = '0;
            n_lane.oy = '0;
        end else begin
            n_lane.a  = DIFF_W'(i_point_x);
            n_lane.b  = DIFF_W'(i_point_y);
            n_lane.ox = i_pos_x;
            n_lane.oy = i_pos_y;
        end
        // Angles of pi/2 or more, or below minus pi/2, are folded by pi with a negated start vector.
        n_lane.y = '0;
        if (z_wide[ZW-1] ^ z_wide[ZW-2]) begin
            n_lane.z = {~z_wide[ZW-1], z_wide[ZW-2:0]};
            n_lane.x = -GAIN_Q30;
        end else begin
            n_lane.z = z_wide;
            n_lane.x = GAIN_Q30;
        end
    end

    // Valid flag is control; the lane data needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/bgft_cell.sv =====
// One rotation cell: a single shift-add micro-rotation, registered, passed to the next cell.
module bgft_cell
    import bgft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [TAB_IDX_W-1:0]  i_stage,
    input  logic                  i_valid,
    input  t_lane                 i_lane,
    output logic                  o_valid,
    output t_lane                 o_lane
);

    logic   r_valid;
    t_lane  r_lane;
    t_lane  n_lane;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    logic [ZW-1:0] step_angle;

    assign xs         = $signed(i_lane.x) >>> i_stage;
    assign ys         = $signed(i_lane.y) >>> i_stage;
    assign step_angle = atan_entry(i_stage);

    // Turn toward zero residual; a residual of zero counts as non-negative.
    always_comb begin
        n_lane = i_lane;
        if (!i_lane.z[ZW-1]) begin
            n_lane.x = $signed(i_lane.x) - ys;
            n_lane.y = $signed(i_lane.y) + xs;
            n_lane.z = i_lane.z - step_angle;
        end else begin
            n_lane.x = $signed(i_lane.x) + ys;
            n_lane.y = $signed(i_lane.y) - xs;
            n_lane.z = i_lane.z + step_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/bgft_combine.sv =====
// Back end: four products, rounded sums with offset, then saturation to the output registers.
module bgft_combine
    import bgft_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  t_lane                          i_lane,
    output logic                           o_done,
    output logic signed [COORD_WIDTH-1:0]  o_out_x,
    output logic signed [COORD_WIDTH-1:0]  o_out_y,
    output logic                           o_clipped
);

    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Product stage.
    logic                           r_pv;
    logic                           r_mode;
    logic signed [PROD_W-1:0]       r_ac;
    logic signed [PROD_W-1:0]       r_bs;
    logic signed [PROD_W-1:0]       r_as;
    logic signed [PROD_W-1:0]       r_bc;
    logic signed [COORD_WIDTH-1:0]  r_ox;
    logic signed [COORD_WIDTH-1:0]  r_oy;

    // Sum stage.
    logic                           r_sv;
    logic signed [RND_W-1:0]        r_rx;
    logic signed [RND_W-1:0]        r_ry;
    logic signed [ACC_W-1:0]        n_acc_x;
    logic signed [ACC_W-1:0]        n_acc_y;
    logic signed [ACC_W-1:0]        off_x;
    logic signed [ACC_W-1:0]        off_y;

    // Output stage.
    logic                           r_done;
    logic signed [COORD_WIDTH-1:0]  r_out_x;
    logic signed [COORD_WIDTH-1:0]  r_out_y;
    logic                           r_clipped;
    logic signed [COORD_WIDTH-1:0]  n_out_x;
    logic signed [COORD_WIDTH-1:0]  n_out_y;
    logic                           clip_x;
    logic                           clip_y;
    logic [RND_W-COORD_WIDTH:0]     top_x;
    logic [RND_W-COORD_WIDTH:0]     top_y;

    // Control pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_sv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= i_valid;
            r_sv   <= r_pv;
            r_done <= r_sv;
        end
    end

    // Operand times cosine and sine; x holds the cosine and y the sine.
    always_ff @(posedge i_clk) begin
        r_mode <= i_lane.mode;
        r_ac   <= PROD_W'($signed(i_lane.a) * $signed(i_lane.x));
        r_bs   <= PROD_W'($signed(i_lane.b) * $signed(i_lane.y));
        r_as   <= PROD_W'($signed(i_lane.a) * $signed(i_lane.y));
        r_bc   <= PROD_W'($signed(i_lane.b) * $signed(i_lane.x));
        r_ox   <= i_lane.ox;
        r_oy   <= i_lane.oy;
    end

    // Offset scaled to Q.30 with the rounding half folded into the low bits.
    assign off_x = ACC_W'($signed({r_ox, 1'b1, {(FRAC-1){1'b0}}}));
    assign off_y = ACC_W'($signed({r_oy, 1'b1, {(FRAC-1){1'b0}}}));

    // Body to ground rotates by the heading, ground to body by its negative.
    always_comb begin
        if (r_mode == MODE_G2B) begin
            n_acc_x = ACC_W'(r_ac) + ACC_W'(r_bs) + off_x;
            n_acc_y = ACC_W'(r_bc) - ACC_W'(r_as) + off_y;
        end else begin
            n_acc_x = ACC_W'(r_ac) - ACC_W'(r_bs) + off_x;
            n_acc_y = ACC_W'(r_bc) + ACC_W'(r_as) + off_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx <= n_acc_x[ACC_W-1:FRAC];
        r_ry <= n_acc_y[ACC_W-1:FRAC];
    end

    // Clamp to the coordinate range when the upper bits are not a pure sign extension.
    assign top_x  = r_rx[RND_W-1:COORD_WIDTH-1];
    assign top_y  = r_ry[RND_W-1:COORD_WIDTH-1];
    assign clip_x = !((&top_x) || !(|top_x));
    assign clip_y = !((&top_y) || !(|top_y));

    always_comb begin
        if (clip_x) begin
            n_out_x = r_rx[RND_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            n_out_x = r_rx[COORD_WIDTH-1:0];
        end
        if (clip_y) begin
            n_out_y = r_ry[RND_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            n_out_y = r_ry[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_clipped <= clip_x | clip_y;
    end

    assign o_done    = r_done;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_clipped = r_clipped;

endmodule

// ===== rtl/body_ground_frame_transform_top.sv =====
// Throughput: one item per cycle; entry register, one cell per rotation, then three back-end stages.
// busy is always low, and each result shows on the o_ ports for one cycle with o_done high.
// Reset (synchronous, active low) clears only the valid flags along the pipeline.
// Top level of the planar body/ground frame transform.
module body_ground_frame_transform_top
    import bgft_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_mode,
    input  logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [COORD_WIDTH-1:0]  i_point_y,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_y,
    input  logic signed [ANGLE_WIDTH-1:0]  i_heading,
    output logic                           o_done,
    output logic signed [COORD_WIDTH-1:0]  o_out_x,
    output logic signed [COORD_WIDTH-1:0]  o_out_y,
    output logic                           o_clipped
);

    logic   chain_valid [0:ROTATION_STAGES];
    t_lane  chain_lane  [0:ROTATION_STAGES];

    // The pipeline never stalls, so an item is taken in every cycle that start is high.
    assign busy = 1'b0;

    bgft_entry u_entry (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (start && !busy),
        .i_mode    (i_mode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_heading (i_heading),
        .o_valid   (chain_valid[0]),
        .o_lane    (chain_lane[0])
    );

    // Row of rotation cells, one micro-rotation each.
    for (genvar s = 0; s < ROTATION_STAGES; s++) begin : g_cell
        bgft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (TAB_IDX_W'(s)),
            .i_valid (chain_valid[s]),
            .i_lane  (chain_lane[s]),
            .o_valid (chain_valid[s+1]),
            .o_lane  (chain_lane[s+1])
        );
    end

    bgft_combine u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (chain_valid[ROTATION_STAGES]),
        .i_lane    (chain_lane[ROTATION_STAGES]),
        .o_done    (o_done),
        .o_out_x   (o_out_x),
        .o_out_y   (o_out_y),
        .o_clipped (o_clipped)
    );

endmodule
